// ===== sv/tq_pkg.sv =====
`timescale 1ns / 1ps
// Package for the two-queue page buffer policy core.
// Holds list depths, entry and cell command types, opcode and status codes.
package tq_pkg;

	localparam int FREQ_N  = 32;
	localparam int REC_N   = 16;
	localparam int GHOST_N = 32;

	localparam int IDW  = 31;
	localparam int SZW  = 17;
	localparam int POSW = 8;
	localparam int CNTW = 9;

	typedef logic [IDW-1:0]  id_t;
	typedef logic [SZW-1:0]  size_t;
	typedef logic [POSW-1:0] pos_t;
	typedef logic [CNTW-1:0] cnt_t;

	typedef enum logic [1:0] {
		OP_READ      = 2'd0,
		OP_PUT_CLEAN = 2'd1,
		OP_PUT_MOD   = 2'd2,
		OP_FLUSH     = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_HIT_RECENT = 3'd0,
		ST_HIT_FREQ   = 3'd1,
		ST_INTO_REC   = 3'd2,
		ST_INTO_FREQ  = 3'd3,
		ST_TOO_BIG    = 3'd4,
		ST_RESIZED    = 3'd5,
		ST_ABSENT     = 3'd6,
		ST_REBUILT    = 3'd7
	} status_t;

	localparam logic [1:0] CFG_BUFFER  = 2'd0;
	localparam logic [1:0] CFG_PERCENT = 2'd1;
	localparam logic [1:0] CFG_MAXPAGE = 2'd2;

	localparam logic [31:0] BUFFER_RST  = 32'd65536;
	localparam logic [6:0]  PERCENT_RST = 7'd25;
	localparam logic [15:0] MAXPAGE_RST = 16'd4096;
	localparam logic [31:0] RMAX_RST    = 32'd16384;
	localparam logic [31:0] FMAX_RST    = 32'd49152;

	typedef struct packed {
		logic  valid;
		id_t   id;
		size_t size;
	} ent_t;

	typedef struct packed {
		logic  shift;
		logic  load;
		logic  upd;
		pos_t  pos;
		pos_t  lpos;
		id_t   id;
		size_t size;
	} cmd_t;

endpackage

// ===== sv/tq_if.sv =====
`timescale 1ns / 1ps
// Handshake channels of the two-queue page buffer policy core.
// Request, result and configuration write channels; no dependencies.
interface tq_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [30:0] page_id;
	logic [15:0] page_bytes;
	modport source(output valid, op, page_id, page_bytes, input ready);
	modport sink(input valid, op, page_id, page_bytes, output ready);
endinterface

interface tq_out_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [30:0] evicted_page;
	logic        evicted_from;
	logic        to_ghost;
	logic [2:0]  status;
	logic [31:0] recent_used;
	logic [31:0] frequent_used;
	logic        last;
	modport source(output valid, kind, evicted_page, evicted_from, to_ghost, status,
		recent_used, frequent_used, last, input ready);
	modport sink(input valid, kind, evicted_page, evicted_from, to_ghost, status,
		recent_used, frequent_used, last, output ready);
endinterface

interface tq_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== sv/tq_cell.sv =====
`timescale 1ns / 1ps
// One list slot: holds an entry, compares it to the key, takes its right
// neighbor on a shift, loads on an append, resizes on an update hit. Depends on tq_pkg.
module tq_cell (
	input  logic         clk,
	input  logic         arst_n,
	input  tq_pkg::pos_t idx,
	input  tq_pkg::id_t  key,
	input  tq_pkg::cmd_t cmd,
	input  tq_pkg::ent_t nxt,
	output tq_pkg::ent_t ent,
	output logic         hit
);
	import tq_pkg::*;

	logic  valid_q;
	id_t   id_q;
	size_t size_q;
	logic  take_nxt;
	logic  take_new;

	assign hit      = valid_q && (id_q == key);
	assign take_new = cmd.load && (idx == cmd.lpos);
	assign take_nxt = cmd.shift && (idx >= cmd.pos);
	assign ent      = '{valid: valid_q, id: id_q, size: size_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take_new) begin
			valid_q <= 1'b1;
		end else if (take_nxt) begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_new) begin
			id_q   <= cmd.id;
			size_q <= cmd.size;
		end else if (take_nxt) begin
			id_q   <= nxt.id;
			size_q <= nxt.size;
		end else if (cmd.upd && hit) begin
			size_q <= cmd.size;
		end
	end

endmodule

// ===== sv/tq_budget.sv =====
`timescale 1ns / 1ps
// Budget split: recent and frequent byte budgets from the configuration,
// by reciprocal multiplication for the divide by 100. Depends on tq_pkg.
module tq_budget (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] buf_bytes,
	input  logic [6:0]  pct,
	input  logic [15:0] mpb,
	output logic        busy,
	output logic [31:0] rmax,
	output logic [31:0] fmax
);
	import tq_pkg::*;

	typedef enum logic [4:0] {
		BG_IDLE = 5'b00001,
		BG_QUO  = 5'b00010,
		BG_REM  = 5'b00100,
		BG_FRAC = 5'b01000,
		BG_FIN  = 5'b10000
	} bg_t;

	localparam logic [31:0] RECIP_100  = 32'h51EB851F;
	localparam logic [12:0] RECIP_FRAC = 13'd5243;
	localparam logic [6:0]  DIVISOR    = 7'd100;

	bg_t         st_q;
	logic [25:0] quo_q;
	logic [6:0]  rem_q;
	logic [32:0] qp_q;
	logic [6:0]  frac_q;
	logic [31:0] rmax_q;
	logic [31:0] fmax_q;
	logic [6:0]  pct_c;
	logic [63:0] quo_full;
	logic [13:0] rp;
	logic [26:0] frac_full;
	logic [31:0] share;
	logic [31:0] floor_b;
	logic [31:0] r_sel;

	// buf * pct / 100 = (buf / 100) * pct + (buf % 100) * pct / 100
	assign pct_c     = (pct > DIVISOR) ? DIVISOR : pct;
	assign quo_full  = 64'(buf_bytes) * 64'(RECIP_100);
	assign rp        = 14'(rem_q) * 14'(pct_c);
	assign frac_full = 27'(rp) * 27'(RECIP_FRAC);
	assign share     = qp_q[31:0] + {25'd0, frac_q};
	assign floor_b   = {16'd0, mpb} + 32'd4;
	assign r_sel     = (share < floor_b) ? floor_b : share;
	assign busy      = (st_q != BG_IDLE);
	assign rmax      = rmax_q;
	assign fmax      = fmax_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= BG_IDLE;
			rmax_q <= RMAX_RST;
			fmax_q <= FMAX_RST;
		end else if (start) begin
			st_q <= BG_QUO;
		end else begin
			unique case (st_q)
				BG_IDLE: begin
				end
				BG_QUO: st_q <= BG_REM;
				BG_REM: st_q <= BG_FRAC;
				BG_FRAC: st_q <= BG_FIN;
				BG_FIN: begin
					rmax_q <= r_sel;
					fmax_q <= (buf_bytes > r_sel) ? (buf_bytes - r_sel) : 32'd0;
					st_q   <= BG_IDLE;
				end
				default: st_q <= BG_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == BG_QUO) begin
			quo_q <= quo_full[62:37];
		end else if (st_q == BG_REM) begin
			rem_q <= 7'(buf_bytes - 32'(quo_q) * 32'(DIVISOR));
			qp_q  <= 33'(quo_q) * 33'(pct_c);
		end else if (st_q == BG_FRAC) begin
			frac_q <= frac_full[25:19];
		end
	end

endmodule

// ===== sv/two_queue_page_buffer_policy_core.sv =====
`timescale 1ns / 1ps
// Two-queue page buffer replacement core: recent FIFO, frequent LRU and ghost
// FIFO as rows of tq_cell slots. Depends on tq_pkg, tq_if, tq_cell, tq_budget.
//
// A request is looked up in all lists at once. One that moves no page passes
// through accept, lookup and status; one that moves or resizes a resident page
// in place adds an append or update step, and one that inserts or rebuilds a
// page adds the eviction check before its append, since the check runs once
// even when nothing is evicted. Each eviction adds a check and a report, and an
// evicted id that goes to the ghost FIFO adds a ghost delete and a ghost append
// before the report. Results go out through a one-entry output register, and a
// held result stalls the core. After a configuration write the budget unit runs
// its reciprocal divide by 100, and no request is taken while it is busy.
module two_queue_page_buffer_policy_core (
	input logic      clk,
	input logic      arst_n,
	tq_in_if.sink    in_item,
	tq_out_if.source out_item,
	tq_cfg_if.sink   cfg
);
	import tq_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_LOOK = 9'b000000010,
		S_MR   = 9'b000000100,
		S_GDEL = 9'b000001000,
		S_GADD = 9'b000010000,
		S_EMIT = 9'b000100000,
		S_APP  = 9'b001000000,
		S_UPD  = 9'b010000000,
		S_FIN  = 9'b100000000
	} state_t;

	localparam int F1 = (FREQ_N > 1) ? 1 : 0;
	localparam int R1 = (REC_N > 1) ? 1 : 0;

	// configuration
	logic [31:0] buf_q;
	logic [6:0]  pct_q;
	logic [15:0] mpb_q;
	logic        cfg_wr;
	logic        bg_busy;
	logic [31:0] rmax;
	logic [31:0] fmax;

	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid && cfg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q <= BUFFER_RST;
			pct_q <= PERCENT_RST;
			mpb_q <= MAXPAGE_RST;
		end else if (cfg_wr) begin
			priority case (cfg.index)
				CFG_BUFFER:  buf_q <= cfg.data;
				CFG_PERCENT: pct_q <= cfg.data[6:0];
				CFG_MAXPAGE: mpb_q <= cfg.data[15:0];
				default: begin
				end
			endcase
		end
	end

	tq_budget u_budget (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cfg_wr),
		.buf_bytes(buf_q),
		.pct      (pct_q),
		.mpb      (mpb_q),
		.busy     (bg_busy),
		.rmax     (rmax),
		.fmax     (fmax)
	);

	// request state
	state_t  st_q, st_d;
	op_t     op_q;
	id_t     id_q;
	size_t   req_q;
	id_t     vid_q, vid_d;
	size_t   app_q, app_d;
	size_t   sub_q, sub_d;
	logic    lsel_q, lsel_d, lsel_n;
	logic    slot_q, slot_d;
	logic    skip_q, skip_d;
	logic    ghost_q, ghost_d;
	logic    aupd_q, aupd_d;
	logic    mpos_q, mpos_d;
	status_t status_q, status_d;
	cnt_t    f_cnt_q, f_cnt_d, r_cnt_q, r_cnt_d, g_cnt_q, g_cnt_d;
	logic [31:0] f_used_q, f_used_d, r_used_q, r_used_d;

	// cell rows
	ent_t f_ent [FREQ_N];
	ent_t r_ent [REC_N];
	ent_t g_ent [GHOST_N];
	logic [FREQ_N-1:0]  f_hit;
	logic [REC_N-1:0]   r_hit;
	logic [GHOST_N-1:0] g_hit;
	cmd_t f_cmd, r_cmd, g_cmd, l_cmd;
	id_t  g_key;

	for (genvar i = 0; i < FREQ_N; i++) begin : g_f
		ent_t nxt;
		if (i == FREQ_N - 1) begin : g_end
			assign nxt = '0;
		end else begin : g_mid
			assign nxt = f_ent[i+1];
		end
		tq_cell u_cell (.clk(clk), .arst_n(arst_n), .idx(pos_t'(i)), .key(id_q),
			.cmd(f_cmd), .nxt(nxt), .ent(f_ent[i]), .hit(f_hit[i]));
	end

	for (genvar i = 0; i < REC_N; i++) begin : g_r
		ent_t nxt;
		if (i == REC_N - 1) begin : g_end
			assign nxt = '0;
		end else begin : g_mid
			assign nxt = r_ent[i+1];
		end
		tq_cell u_cell (.clk(clk), .arst_n(arst_n), .idx(pos_t'(i)), .key(id_q),
			.cmd(r_cmd), .nxt(nxt), .ent(r_ent[i]), .hit(r_hit[i]));
	end

	for (genvar i = 0; i < GHOST_N; i++) begin : g_g
		ent_t nxt;
		if (i == GHOST_N - 1) begin : g_end
			assign nxt = '0;
		end else begin : g_mid
			assign nxt = g_ent[i+1];
		end
		tq_cell u_cell (.clk(clk), .arst_n(arst_n), .idx(pos_t'(i)), .key(g_key),
			.cmd(g_cmd), .nxt(nxt), .ent(g_ent[i]), .hit(g_hit[i]));
	end

	assign g_key = (st_q == S_GDEL) ? vid_q : id_q;

	// hit encoding
	logic  f_any, r_any, g_any;
	pos_t  f_pos, r_pos, g_pos;
	size_t f_sz, r_sz;

	always_comb begin
		f_any = 1'b0;
		f_pos = '0;
		f_sz  = '0;
		for (int i = 0; i < FREQ_N; i++) begin
			if (f_hit[i]) begin
				f_any = 1'b1;
				f_pos = f_pos | pos_t'(i);
				f_sz  = f_sz | f_ent[i].size;
			end
		end
	end

	always_comb begin
		r_any = 1'b0;
		r_pos = '0;
		r_sz  = '0;
		for (int i = 0; i < REC_N; i++) begin
			if (r_hit[i]) begin
				r_any = 1'b1;
				r_pos = r_pos | pos_t'(i);
				r_sz  = r_sz | r_ent[i].size;
			end
		end
	end

	always_comb begin
		g_any = 1'b0;
		g_pos = '0;
		for (int i = 0; i < GHOST_N; i++) begin
			if (g_hit[i]) begin
				g_any = 1'b1;
				g_pos = g_pos | pos_t'(i);
			end
		end
	end

	// selected list view
	logic        hit;
	pos_t        hpos;
	size_t       hsz;
	cnt_t        l_cnt, l_cnt_d, l_cap;
	pos_t        l_last;
	logic [31:0] l_used, l_used_d, l_bud;
	ent_t        l_e0, l_em;
	size_t       sub_sel;
	logic        fit, slot_ok, too_big, out_free, out_load;
	logic        o_kind;
	status_t     o_status;

	assign hit     = f_any || r_any;
	assign hpos    = f_any ? f_pos : r_pos;
	assign hsz     = f_any ? f_sz : r_sz;
	assign lsel_n  = (st_q == S_LOOK) ? (f_any ? 1'b0 : (r_any ? 1'b1 : !g_any)) : lsel_q;
	assign l_cnt   = lsel_n ? r_cnt_q : f_cnt_q;
	assign l_cap   = lsel_n ? cnt_t'(REC_N) : cnt_t'(FREQ_N);
	assign l_last  = lsel_n ? pos_t'(REC_N - 1) : pos_t'(FREQ_N - 1);
	assign l_used  = lsel_n ? r_used_q : f_used_q;
	assign l_bud   = lsel_n ? rmax : fmax;
	assign l_e0    = lsel_n ? r_ent[0] : f_ent[0];
	assign l_em    = mpos_q ? (lsel_n ? r_ent[R1] : f_ent[F1]) : l_e0;
	assign sub_sel = (st_q == S_LOOK) ? hsz : sub_q;
	assign fit     = ({2'b0, l_used} + 34'(req_q) - 34'(sub_sel)) <= {2'b0, l_bud};
	assign slot_ok = !slot_q || (l_cnt < l_cap);
	assign too_big = buf_q < 32'(req_q);
	assign out_free = !out_item.valid || out_item.ready;

	always_comb begin
		st_d     = st_q;
		vid_d    = vid_q;
		app_d    = app_q;
		sub_d    = sub_q;
		lsel_d   = lsel_n;
		slot_d   = slot_q;
		skip_d   = skip_q;
		ghost_d  = ghost_q;
		aupd_d   = aupd_q;
		mpos_d   = mpos_q;
		status_d = status_q;
		g_cnt_d  = g_cnt_q;
		l_cnt_d  = l_cnt;
		l_used_d = l_used;
		l_cmd    = '0;
		l_cmd.id   = id_q;
		l_cmd.size = app_q;
		g_cmd    = '0;
		g_cmd.id = vid_q;
		out_load = 1'b0;
		o_kind   = 1'b0;
		o_status = ST_HIT_RECENT;

		unique case (st_q)
			S_IDLE: begin
				if (in_item.valid && in_item.ready) begin
					st_d = S_LOOK;
				end
			end
			S_LOOK: begin
				mpos_d = 1'b0;
				sub_d  = '0;
				slot_d = 1'b1;
				skip_d = 1'b0;
				ghost_d = 1'b0;
				aupd_d = 1'b0;
				app_d  = req_q;
				if (op_q == OP_FLUSH) begin
					if (!hit) begin
						status_d = ST_ABSENT;
						st_d     = S_FIN;
					end else begin
						status_d = ST_RESIZED;
						if (!fit) begin
							sub_d  = hsz;
							slot_d = 1'b0;
							skip_d = 1'b1;
							aupd_d = 1'b1;
							st_d   = S_MR;
						end else begin
							st_d = S_UPD;
						end
					end
				end else if (op_q == OP_READ && hit) begin
					if (f_any) begin
						status_d  = ST_HIT_FREQ;
						l_cmd.shift = 1'b1;
						l_cmd.pos = hpos;
						l_cnt_d   = l_cnt - cnt_t'(1);
						l_used_d  = l_used - 32'(hsz);
						app_d     = hsz;
						st_d      = S_APP;
					end else begin
						status_d = ST_HIT_RECENT;
						st_d     = S_FIN;
					end
				end else if (too_big) begin
					status_d = ST_TOO_BIG;
					st_d     = S_FIN;
				end else if (hit) begin
					status_d = f_any ? ST_HIT_FREQ : ST_HIT_RECENT;
					st_d     = S_FIN;
					if (op_q == OP_PUT_MOD) begin
						if (fit && !f_any) begin
							status_d = ST_RESIZED;
							st_d     = S_UPD;
						end else begin
							status_d    = fit ? ST_RESIZED : ST_REBUILT;
							l_cmd.shift = 1'b1;
							l_cmd.pos   = hpos;
							l_cnt_d     = l_cnt - cnt_t'(1);
							l_used_d    = l_used - 32'(hsz);
							st_d        = fit ? S_APP : S_MR;
						end
					end
				end else if (g_any) begin
					g_cmd.shift = 1'b1;
					g_cmd.pos   = g_pos;
					g_cnt_d     = g_cnt_q - cnt_t'(1);
					status_d    = ST_INTO_FREQ;
					st_d        = S_MR;
				end else begin
					ghost_d  = 1'b1;
					status_d = ST_INTO_REC;
					st_d     = S_MR;
				end
			end
			S_MR: begin
				if (!(cnt_t'(mpos_q) < l_cnt) || (fit && slot_ok)) begin
					st_d = aupd_q ? S_UPD : S_APP;
				end else if (skip_q && (l_em.id == id_q)) begin
					mpos_d = 1'b1;
				end else begin
					l_cmd.shift = 1'b1;
					l_cmd.pos   = pos_t'(mpos_q);
					l_cnt_d     = l_cnt - cnt_t'(1);
					l_used_d    = l_used - 32'(l_em.size);
					vid_d       = l_em.id;
					st_d        = ghost_q ? S_GDEL : S_EMIT;
				end
			end
			S_GDEL: begin
				if (g_any) begin
					g_cmd.shift = 1'b1;
					g_cmd.pos   = g_pos;
					g_cnt_d     = g_cnt_q - cnt_t'(1);
				end
				st_d = S_GADD;
			end
			S_GADD: begin
				g_cmd.load = 1'b1;
				if (g_cnt_q >= cnt_t'(GHOST_N)) begin
					g_cmd.shift = 1'b1;
					g_cmd.pos   = '0;
					g_cmd.lpos  = pos_t'(GHOST_N - 1);
				end else begin
					g_cmd.lpos = g_cnt_q[POSW-1:0];
					g_cnt_d    = g_cnt_q + cnt_t'(1);
				end
				st_d = S_EMIT;
			end
			S_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					st_d     = S_MR;
				end
			end
			S_APP: begin
				l_cmd.load = 1'b1;
				if (l_cnt >= l_cap) begin
					l_cmd.shift = 1'b1;
					l_cmd.pos   = '0;
					l_cmd.lpos  = l_last;
					l_used_d    = l_used - 32'(l_e0.size) + 32'(app_q);
				end else begin
					l_cmd.lpos = l_cnt[POSW-1:0];
					l_cnt_d    = l_cnt + cnt_t'(1);
					l_used_d   = l_used + 32'(app_q);
				end
				st_d = S_FIN;
			end
			S_UPD: begin
				l_cmd.upd  = 1'b1;
				l_cmd.size = req_q;
				l_used_d   = l_used - 32'(hsz) + 32'(req_q);
				st_d       = S_FIN;
			end
			S_FIN: begin
				if (out_free) begin
					out_load = 1'b1;
					o_kind   = 1'b1;
					o_status = status_q;
					st_d     = S_IDLE;
				end
			end
			default: st_d = S_IDLE;
		endcase
	end

	always_comb begin
		f_cmd    = '0;
		r_cmd    = '0;
		f_cnt_d  = f_cnt_q;
		r_cnt_d  = r_cnt_q;
		f_used_d = f_used_q;
		r_used_d = r_used_q;
		if (lsel_n) begin
			r_cmd    = l_cmd;
			r_cnt_d  = l_cnt_d;
			r_used_d = l_used_d;
		end else begin
			f_cmd    = l_cmd;
			f_cnt_d  = l_cnt_d;
			f_used_d = l_used_d;
		end
	end

	assign in_item.ready = (st_q == S_IDLE) && !bg_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_IDLE;
			f_cnt_q  <= '0;
			r_cnt_q  <= '0;
			g_cnt_q  <= '0;
			f_used_q <= '0;
			r_used_q <= '0;
		end else begin
			st_q     <= st_d;
			f_cnt_q  <= f_cnt_d;
			r_cnt_q  <= r_cnt_d;
			g_cnt_q  <= g_cnt_d;
			f_used_q <= f_used_d;
			r_used_q <= r_used_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_item.valid && in_item.ready) begin
			op_q  <= op_t'(in_item.op);
			id_q  <= in_item.page_id;
			req_q <= size_t'(in_item.page_bytes) + size_t'(4);
		end
		vid_q    <= vid_d;
		app_q    <= app_d;
		sub_q    <= sub_d;
		lsel_q   <= lsel_d;
		slot_q   <= slot_d;
		skip_q   <= skip_d;
		ghost_q  <= ghost_d;
		aupd_q   <= aupd_d;
		mpos_q   <= mpos_d;
		status_q <= status_d;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_item.valid <= 1'b0;
		end else if (out_load) begin
			out_item.valid <= 1'b1;
		end else if (out_item.ready) begin
			out_item.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_item.kind          <= o_kind;
			out_item.last          <= o_kind;
			out_item.evicted_page  <= o_kind ? '0 : vid_q;
			out_item.evicted_from  <= o_kind ? 1'b0 : lsel_q;
			out_item.to_ghost      <= o_kind ? 1'b0 : ghost_q;
			out_item.status        <= o_status;
			out_item.recent_used   <= r_used_q;
			out_item.frequent_used <= f_used_q;
		end
	end

endmodule

// ===== tb/sv/two_queue_page_buffer_policy_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the two-queue page buffer policy core: random and
// directed page requests checked against a behavioral 2Q model.
// Depends on tq_pkg, tq_if and the core RTL.
module two_queue_page_buffer_policy_core_test;
	import tq_pkg::*;

	typedef struct packed {
		op_t         op;
		logic [30:0] id;
		logic [15:0] bytes;
	} req_t;

	typedef struct packed {
		logic        kind;
		logic [30:0] page;
		logic        from;
		logic        ghost;
		logic [2:0]  status;
		logic [31:0] rused;
		logic [31:0] fused;
		logic        last;
	} res_t;

	logic clk = 0;
	logic arst_n = 0;
	tq_in_if  in_item();
	tq_out_if out_item();
	tq_cfg_if cfg();

	two_queue_page_buffer_policy_core dut(.clk(clk), .arst_n(arst_n), .in_item(in_item),
		.out_item(out_item), .cfg(cfg));

	always #5 clk = ~clk;

	// page buffer model
	logic [31:0] m_buf, m_pct, m_maxpg;
	logic [31:0] f_id[$], f_sz[$], r_id[$], r_sz[$], g_id[$];
	logic [31:0] r_used, f_used;
	res_t expected_results[$];
	req_t pending_reqs[$];
	int errors = 0;
	int idle_cnt = 0;
	bit no_gaps = 0;
	bit hold_long = 0;
	bit in_taken = 0;
	int sink_stall = 0, src_gap = 0;

	function automatic void push_res(bit kind, logic [30:0] page, bit from, bit gh,
		logic [2:0] st);
		res_t r;
		r.kind = kind; r.page = page; r.from = from; r.ghost = gh; r.status = st;
		r.rused = r_used; r.fused = f_used; r.last = kind;
		expected_results.push_back(r);
	endfunction

	function automatic int find_in(ref logic [31:0] q[$], input logic [31:0] id);
		foreach (q[i]) if (q[i] == id) return i;
		return -1;
	endfunction

	function automatic void ghost_add(logic [31:0] id);
		int p;
		p = find_in(g_id, id);
		if (p >= 0) g_id.delete(p);
		if (g_id.size() >= GHOST_N) g_id.delete(0);
		g_id.push_back(id);
	endfunction

	// evict oldest entries of one list until the cost fits
	function automatic void evict_list(bit rec, longint budget, longint sub, longint add,
		bit need_slot, bit has_skip, logic [31:0] skip, bit gh);
		int pos, cap;
		logic [31:0] vid;
		pos = 0;
		cap = rec ? REC_N : FREQ_N;
		while (pos < (rec ? r_id.size() : f_id.size())) begin
			longint used;
			used = rec ? r_used : f_used;
			if (used - sub + add <= budget &&
				(!need_slot || (rec ? r_id.size() : f_id.size()) < cap)) break;
			if (has_skip && (rec ? r_id[pos] : f_id[pos]) == skip) begin
				pos++;
				continue;
			end
			if (rec) begin
				vid = r_id[pos]; r_used -= r_sz[pos];
				r_id.delete(pos); r_sz.delete(pos);
			end else begin
				vid = f_id[pos]; f_used -= f_sz[pos];
				f_id.delete(pos); f_sz.delete(pos);
			end
			if (gh) ghost_add(vid);
			push_res(0, vid[30:0], rec, gh, 3'd0);
		end
	endfunction

	function automatic void append_list(bit rec, logic [31:0] id, logic [31:0] sz);
		if (rec) begin
			if (r_id.size() >= REC_N) begin
				r_used -= r_sz[0]; r_id.delete(0); r_sz.delete(0);
			end
			r_id.push_back(id); r_sz.push_back(sz); r_used += sz;
		end else begin
			if (f_id.size() >= FREQ_N) begin
				f_used -= f_sz[0]; f_id.delete(0); f_sz.delete(0);
			end
			f_id.push_back(id); f_sz.push_back(sz); f_used += sz;
		end
	endfunction

	function automatic void predict_request(req_t q);
		longint pct, rmax, fmax, bud, usd;
		logic [31:0] id, req, old;
		int fp, rp, pos, gp;
		bit hit, rec;
		status_t st;
		id = {1'b0, q.id};
		req = q.bytes + 32'd4;
		pct = m_pct > 100 ? 100 : m_pct;
		rmax = longint'(m_buf) * pct / 100;
		if (rmax < longint'(m_maxpg) + 4) rmax = longint'(m_maxpg) + 4;
		fmax = m_buf > rmax ? m_buf - rmax : 0;
		fp = find_in(f_id, id);
		rp = find_in(r_id, id);
		hit = fp >= 0 || rp >= 0;
		rec = fp < 0;
		pos = rec ? rp : fp;
		bud = rec ? rmax : fmax;
		if (hit) begin
			old = rec ? r_sz[pos] : f_sz[pos];
			usd = rec ? r_used : f_used;
		end
		if (q.op == OP_FLUSH) begin
			if (!hit) st = ST_ABSENT;
			else begin
				if (usd - old + req > bud) begin
					evict_list(rec, bud, old, req, 0, 1, id, 0);
					pos = rec ? find_in(r_id, id) : find_in(f_id, id);
				end
				if (rec) begin
					r_used = r_used - r_sz[pos] + req; r_sz[pos] = req;
				end else begin
					f_used = f_used - f_sz[pos] + req; f_sz[pos] = req;
				end
				st = ST_RESIZED;
			end
		end else if (q.op == OP_READ && hit) begin
			if (!rec) begin
				f_used -= old; f_id.delete(pos); f_sz.delete(pos);
				append_list(0, id, old);
				st = ST_HIT_FREQ;
			end else st = ST_HIT_RECENT;
		end else if (longint'(m_buf) < longint'(req)) st = ST_TOO_BIG;
		else if (hit) begin
			st = rec ? ST_HIT_RECENT : ST_HIT_FREQ;
			if (q.op == OP_PUT_MOD) begin
				if (usd - old + req <= bud) begin
					if (!rec) begin
						f_used -= old; f_id.delete(pos); f_sz.delete(pos);
						append_list(0, id, req);
					end else begin
						r_used = r_used - old + req; r_sz[pos] = req;
					end
					st = ST_RESIZED;
				end else begin
					if (rec) begin
						r_used -= old; r_id.delete(pos); r_sz.delete(pos);
					end else begin
						f_used -= old; f_id.delete(pos); f_sz.delete(pos);
					end
					evict_list(rec, bud, 0, req, 1, 0, 0, 0);
					append_list(rec, id, req);
					st = ST_REBUILT;
				end
			end
		end else begin
			gp = find_in(g_id, id);
			if (gp >= 0) begin
				g_id.delete(gp);
				evict_list(0, fmax, 0, req, 1, 0, 0, 0);
				append_list(0, id, req);
				st = ST_INTO_FREQ;
			end else begin
				evict_list(1, rmax, 0, req, 1, 0, 0, 1);
				append_list(1, id, req);
				st = ST_INTO_REC;
			end
		end
		push_res(1, 0, 0, 0, st);
	endfunction

	// request taken at the last rising edge
	always @(posedge clk) begin
		in_taken <= arst_n && in_item.valid && in_item.ready;
	end

	// request driver
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_item.valid <= 0;
			in_item.op <= OP_READ;
			in_item.page_id <= 0;
			in_item.page_bytes <= 0;
			src_gap <= 0;
		end else if (!in_item.valid || in_taken) begin
			if (src_gap > 0) begin
				in_item.valid <= 0;
				src_gap <= src_gap - 1;
			end else if (!no_gaps && $urandom_range(0, 9) == 0) begin
				in_item.valid <= 0;
				src_gap <= $urandom_range(0, 8);
			end else if (pending_reqs.size() > 0) begin
				req_t q;
				q = pending_reqs.pop_front();
				in_item.valid <= 1;
				in_item.op <= q.op;
				in_item.page_id <= q.id;
				in_item.page_bytes <= q.bytes;
			end else in_item.valid <= 0;
		end
	end

	// result ready
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_item.ready <= 0;
			sink_stall <= 0;
		end else if (hold_long) out_item.ready <= 0;
		else if (sink_stall > 0) begin
			out_item.ready <= 0;
			sink_stall <= sink_stall - 1;
		end else if (!no_gaps && $urandom_range(0, 9) == 0) begin
			out_item.ready <= 0;
			sink_stall <= $urandom_range(0, 8);
		end else out_item.ready <= 1;
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_item.valid && in_item.ready) begin
				req_t q;
				q.op = op_t'(in_item.op);
				q.id = in_item.page_id;
				q.bytes = in_item.page_bytes;
				predict_request(q);
			end
			if (out_item.valid && out_item.ready) begin
				res_t e;
				if (expected_results.size() == 0) begin
					$error("unexpected result kind=%0d", out_item.kind);
					errors++;
				end else begin
					e = expected_results.pop_front();
					if (out_item.kind !== e.kind) begin
						$error("kind exp %0d got %0d", e.kind, out_item.kind); errors++;
					end
					if (out_item.evicted_page !== e.page) begin
						$error("evicted_page exp %0d got %0d", e.page, out_item.evicted_page);
						errors++;
					end
					if (out_item.evicted_from !== e.from) begin
						$error("evicted_from exp %0d got %0d", e.from, out_item.evicted_from);
						errors++;
					end
					if (out_item.to_ghost !== e.ghost) begin
						$error("to_ghost exp %0d got %0d", e.ghost, out_item.to_ghost);
						errors++;
					end
					if (out_item.status !== e.status) begin
						$error("status exp %0d got %0d", e.status, out_item.status); errors++;
					end
					if (out_item.recent_used !== e.rused) begin
						$error("recent_used exp %0d got %0d", e.rused, out_item.recent_used);
						errors++;
					end
					if (out_item.frequent_used !== e.fused) begin
						$error("frequent_used exp %0d got %0d", e.fused, out_item.frequent_used);
						errors++;
					end
					if (out_item.last !== e.last) begin
						$error("last exp %0d got %0d", e.last, out_item.last); errors++;
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_item.valid && in_item.ready) || (out_item.valid && out_item.ready) ||
			(cfg.valid && cfg.ready) || hold_long) idle_cnt <= 0;
		else idle_cnt <= idle_cnt + 1;
		if (idle_cnt > 20000) begin
			$display("[two_queue_page_buffer_policy_core] ERROR");
			$finish;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg.valid <= 1;
		cfg.index <= idx;
		cfg.data <= val;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		if (idx == CFG_BUFFER) m_buf = val;
		else if (idx == CFG_PERCENT) m_pct = val[6:0];
		else if (idx == CFG_MAXPAGE) m_maxpg = val[15:0];
		@(negedge clk);
		cfg.valid <= 0;
	endtask

	task automatic drain;
		while (pending_reqs.size() > 0 || in_item.valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	function automatic void add_req(op_t op, logic [30:0] id, logic [15:0] b);
		req_t q;
		q.op = op; q.id = id; q.bytes = b;
		pending_reqs.push_back(q);
	endfunction

	// mostly small ids so lists, ghosts and evictions interact
	task automatic random_phase(int n, int maxb);
		repeat (n) begin
			logic [30:0] id;
			if ($urandom_range(0, 19) == 0) id = 31'($urandom());
			else id = 31'($urandom_range(0, 47));
			add_req(op_t'($urandom_range(0, 3)), id,
				$urandom_range(0, 7) == 0 ? 16'($urandom()) : 16'($urandom_range(0, maxb)));
		end
	endtask

	initial begin
		m_buf = BUFFER_RST; m_pct = PERCENT_RST; m_maxpg = MAXPAGE_RST;
		r_used = 0; f_used = 0;
		cfg.valid = 0; cfg.index = CFG_BUFFER; cfg.data = 0;
		repeat (10) @(posedge clk);
		arst_n = 1;
		repeat (50) @(posedge clk);

		// directed: extremes, every op, ghost promotion, too big, absent flush
		add_req(OP_FLUSH, 31'd5, 16'd10);
		add_req(OP_READ, 31'h7FFFFFFF, 16'hFFFF);
		add_req(OP_PUT_CLEAN, 31'd1, 16'd4000);
		add_req(OP_PUT_CLEAN, 31'd2, 16'd4000);
		add_req(OP_PUT_CLEAN, 31'd3, 16'd4000);
		add_req(OP_PUT_CLEAN, 31'd4, 16'd4000);
		add_req(OP_PUT_CLEAN, 31'd5, 16'd4000);
		add_req(OP_READ, 31'd1, 16'd0);
		add_req(OP_PUT_MOD, 31'd1, 16'd100);
		add_req(OP_READ, 31'd1, 16'd0);
		add_req(OP_PUT_MOD, 31'd1, 16'd200);
		add_req(OP_READ, 31'd5, 16'd0);
		add_req(OP_PUT_MOD, 31'd5, 16'd12000);
		add_req(OP_FLUSH, 31'd5, 16'd15000);
		add_req(OP_PUT_CLEAN, 31'd1, 16'd0);
		add_req(OP_PUT_MOD, 31'd1, 16'hFFFF);
		add_req(OP_FLUSH, 31'd1, 16'd30000);
		add_req(OP_PUT_CLEAN, 31'h7FFFFFFF, 16'd0);
		random_phase(40, 1000);
		drain();

		write_reg(CFG_BUFFER, 32'd3000);
		write_reg(CFG_PERCENT, 7'd50);
		write_reg(CFG_MAXPAGE, 16'd200);
		repeat (60) @(posedge clk);
		random_phase(90, 400);
		// stall results while requests keep coming
		fork
			begin
				hold_long = 1;
				repeat (400) @(posedge clk);
				hold_long = 0;
			end
		join_none
		drain();

		write_reg(CFG_BUFFER, 32'd0);
		write_reg(CFG_PERCENT, 7'd127);
		write_reg(CFG_MAXPAGE, 16'hFFFF);
		repeat (60) @(posedge clk);
		random_phase(20, 100);
		drain();

		write_reg(CFG_BUFFER, 32'hFFFFFFFF);
		write_reg(CFG_PERCENT, 7'd0);
		write_reg(CFG_MAXPAGE, 16'd0);
		write_reg(2'd3, 32'd1234);
		repeat (60) @(posedge clk);
		random_phase(80, 65535);
		drain();

		write_reg(CFG_BUFFER, 32'd1200);
		write_reg(CFG_PERCENT, 7'd100);
		write_reg(CFG_MAXPAGE, 16'd50);
		repeat (60) @(posedge clk);
		random_phase(90, 150);
		drain();

		write_reg(CFG_BUFFER, 32'd8000);
		write_reg(CFG_PERCENT, 7'd30);
		write_reg(CFG_MAXPAGE, 16'd300);
		repeat (60) @(posedge clk);
		no_gaps = 1;
		random_phase(70, 600);
		drain();

		if (errors == 0) $display("[two_queue_page_buffer_policy_core] OK");
		else $display("[two_queue_page_buffer_policy_core] ERROR");
		$finish;
	end
endmodule
